### sv/rfa_pkg.sv
// Package for the Rastrigin fitness accumulator: widths, pipeline stage structs
// and the quarter-wave cosine ROM contents. No dependencies.
`default_nettype none

package rfa_pkg;

  // Number formats
  localparam int COORD_W         = 16;  // signed Q3.F coordinate
  localparam int COORD_FRAC_BITS = 12;  // F
  localparam int COS_FRAC_BITS   = 14;  // C
  localparam int SUM_WIDTH       = 40;
  localparam int AMP_W           = 8;
  localparam int FIT_W           = 40;  // fitness field on the output bus

  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(10);

  // Quarter-wave table: index 0 .. 2^(F-2), magnitude 0 .. 2^C
  localparam int LUT_DEPTH = (1 << (COORD_FRAC_BITS - 2)) + 1;
  localparam int LUT_AW    = COORD_FRAC_BITS - 1;
  localparam int COS_W     = COS_FRAC_BITS + 1;

  // Alignment of A*c to Q.F (floor shift right, or shift left)
  localparam int COS_SHR = (COS_FRAC_BITS >= COORD_FRAC_BITS) ?
                           (COS_FRAC_BITS - COORD_FRAC_BITS) : 0;
  localparam int COS_SHL = (COS_FRAC_BITS >= COORD_FRAC_BITS) ?
                           0 : (COORD_FRAC_BITS - COS_FRAC_BITS);

  localparam int SQ_W   = 2 * COORD_W - COORD_FRAC_BITS;
  localparam int OFS_W  = AMP_W + COORD_FRAC_BITS;
  localparam int PROD_W = AMP_W + 1 + COS_W + 1;
  localparam int CT_W   = PROD_W + COS_SHL;
  localparam int TERM_MAX_W = (SQ_W > OFS_W) ? ((SQ_W > CT_W) ? SQ_W : CT_W) :
                              ((OFS_W > CT_W) ? OFS_W : CT_W);
  localparam int TERM_W = TERM_MAX_W + 2;  // signed working width of one term

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  typedef logic [COS_W-1:0] cos_lut_t [LUT_DEPTH];

  localparam real PI = 3.14159265358979323846;
  // Angle of one phase step, 2*pi / 2^F
  localparam real PHASE_STEP = 2.0 * PI / real'(1 << COORD_FRAC_BITS);

  function automatic cos_lut_t build_cos_lut();
    cos_lut_t lut;
    real      ang;
    real      v;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      ang    = PHASE_STEP * real'(i);
      v      = $cos(ang) * real'(1 << COS_FRAC_BITS);
      lut[i] = COS_W'($rtoi(v + 0.5));
    end
    return lut;
  endfunction

  localparam cos_lut_t COS_LUT = build_cos_lut();

  // Stage 1 -> stage 2
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic signed [COORD_W-1:0] coord;
    logic                      neg;
    logic [COS_W-1:0]          cos_mag;
  } rfa_lookup_t;

  // Stage 2 -> stage 3
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [TERM_W-2:0] term;
  } rfa_term_t;

endpackage

`default_nettype wire

### sv/rfa_lookup.sv
// Stage 1: phase folding and registered quarter-wave cosine ROM read.
// Depends on rfa_pkg.
`default_nettype none

module rfa_lookup (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [rfa_pkg::COORD_W-1:0] coord_i,
  input  wire logic                               last_i,
  input  wire logic                               next_ready_i,
  output rfa_pkg::rfa_lookup_t                    lookup_o
);

  localparam int F = rfa_pkg::COORD_FRAC_BITS;
  localparam logic [F:0] FULL    = (F + 1)'(1 << F);
  localparam logic [F:0] HALF    = (F + 1)'(1 << (F - 1));
  localparam logic [F:0] QUARTER = (F + 1)'(1 << (F - 2));

  logic [F:0]                   phase;
  logic [F:0]                   fold;
  logic                         neg;
  logic [rfa_pkg::LUT_AW-1:0]   idx;
  logic                         load;

  logic                               valid_q;
  logic                               last_q;
  logic signed [rfa_pkg::COORD_W-1:0] coord_q;
  logic                               neg_q;
  logic [rfa_pkg::COS_W-1:0]          cos_q;

  // Fold the phase into the first quarter; cosine sign flips in the second and third quarters.
  always_comb begin
    phase = {1'b0, coord_i[F-1:0]};
    fold  = phase;
    neg   = 1'b0;
    if (phase > HALF) begin
      fold = FULL - phase;
    end
    if (fold > QUARTER) begin
      fold = HALF - fold;
      neg  = 1'b1;
    end
    idx = fold[rfa_pkg::LUT_AW-1:0];
  end

  assign in_ready_o = !valid_q || next_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q  <= last_i;
      coord_q <= coord_i;
      neg_q   <= neg;
      cos_q   <= rfa_pkg::COS_LUT[idx];
    end
  end

  assign lookup_o = '{valid: valid_q, last: last_q, coord: coord_q, neg: neg_q,
                      cos_mag: cos_q};

endmodule

`default_nettype wire

### sv/rfa_term.sv
// Stage 2: one Rastrigin term A + x^2 - A*cos(2*pi*x) in Q.F, clamped at zero.
// Depends on rfa_pkg.
`default_nettype none

module rfa_term (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [rfa_pkg::AMP_W-1:0]   amplitude_i,
  input  wire rfa_pkg::rfa_lookup_t        lookup_i,
  output logic                             in_ready_o,
  input  wire logic                        next_ready_i,
  output rfa_pkg::rfa_term_t               term_o
);

  localparam int F  = rfa_pkg::COORD_FRAC_BITS;
  localparam int CW = rfa_pkg::COORD_W;
  localparam int TW = rfa_pkg::TERM_W;

  logic signed [2*CW-1:0]              sq_full;
  logic [rfa_pkg::SQ_W-1:0]            sq;
  logic signed [rfa_pkg::COS_W:0]      cos_s;
  logic signed [rfa_pkg::PROD_W-1:0]   prod;
  logic signed [TW-1:0]                cos_term;
  logic signed [TW-1:0]                offset;
  logic signed [TW-1:0]                term;
  logic [TW-2:0]                       term_d;
  logic                                load;

  logic              valid_q;
  logic              last_q;
  logic [TW-2:0]     term_q;

  always_comb begin
    sq_full  = lookup_i.coord * lookup_i.coord;
    sq       = sq_full[2*CW-1:F];
    cos_s    = lookup_i.neg ? -$signed({1'b0, lookup_i.cos_mag})
                            :  $signed({1'b0, lookup_i.cos_mag});
    prod     = $signed({1'b0, amplitude_i}) * cos_s;
    cos_term = (TW'(prod) >>> rfa_pkg::COS_SHR) <<< rfa_pkg::COS_SHL;
    offset   = $signed(TW'({amplitude_i, {F{1'b0}}}));
    term     = offset + $signed(TW'(sq)) - cos_term;
    term_d   = term[TW-1] ? '0 : term[TW-2:0];
  end

  assign in_ready_o = !valid_q || next_ready_i;
  assign load       = lookup_i.valid && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= lookup_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= lookup_i.last;
      term_q <= term_d;
    end
  end

  assign term_o = '{valid: valid_q, last: last_q, term: term_q};

endmodule

`default_nettype wire

### sv/rfa_accum.sv
// Stage 3: saturating accumulator and output register; emits and clears on last.
// Depends on rfa_pkg.
`default_nettype none

module rfa_accum (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rfa_pkg::rfa_term_t          term_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rfa_pkg::FIT_W-1:0]        fitness_o,
  output logic                             saturated_o
);

  localparam int SW = rfa_pkg::SUM_WIDTH;

  logic [SW:0]    sum_raw;
  logic [SW-1:0]  acc_d;
  logic           ovf_d;
  logic           out_free;
  logic           fire;

  logic [SW-1:0]               acc_q;
  logic                        ovf_q;
  logic                        out_valid_q;
  logic [rfa_pkg::FIT_W-1:0]   fitness_q;
  logic                        saturated_q;

  // Carry out of the sum means the true sum exceeds the maximum.
  always_comb begin
    sum_raw = {1'b0, acc_q} + {1'b0, SW'(term_i.term)};
    if (sum_raw[SW]) begin
      acc_d = rfa_pkg::SUM_MAX;
      ovf_d = 1'b1;
    end else begin
      acc_d = sum_raw[SW-1:0];
      ovf_d = ovf_q;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !term_i.last || out_free;
  assign fire       = term_i.valid && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        if (term_i.last) begin
          acc_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          acc_q <= acc_d;
          ovf_q <= ovf_d;
        end
      end
      if (fire && term_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && term_i.last) begin
      fitness_q   <= rfa_pkg::FIT_W'(acc_d);
      saturated_q <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fitness_o   = fitness_q;
  assign saturated_o = saturated_q;

endmodule

`default_nettype wire

### sv/rastrigin_fitness_accumulator.sv
// Rastrigin fitness accumulator, top level. The last coordinate passes the
// ROM lookup, term and accumulate registers before its result is output.
// Throughput: one coordinate per cycle while the output is not stalled; the
// three-stage pipeline with registered cosine ROM read sets it.
// Reset clears the sum, the saturation flag and all stage valids, and sets the
// amplitude to 10. Depends on rfa_pkg, rfa_lookup, rfa_term, rfa_accum.
`default_nettype none

module rastrigin_fitness_accumulator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rfa_pkg::AMP_W-1:0]  cfg_wdata_i,     // amplitude
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [15:0]                s_axis_tdata_i,  // [15:0] coordinate
  input  wire logic                       s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic [39:0]                     m_axis_tdata_o,  // [39:0] fitness
  output logic                            m_axis_tuser_o   // [0] saturated
);

  logic [rfa_pkg::AMP_W-1:0] amplitude_q;
  rfa_pkg::rfa_lookup_t      lookup;
  rfa_pkg::rfa_term_t        term;
  logic                      term_ready;
  logic                      accum_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q <= rfa_pkg::AMP_RESET;
    end else if (cfg_we_i) begin
      amplitude_q <= cfg_wdata_i;
    end
  end

  rfa_lookup u_lookup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .coord_i      ($signed(s_axis_tdata_i[rfa_pkg::COORD_W-1:0])),
    .last_i       (s_axis_tlast_i),
    .next_ready_i (term_ready),
    .lookup_o     (lookup)
  );

  rfa_term u_term (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .amplitude_i  (amplitude_q),
    .lookup_i     (lookup),
    .in_ready_o   (term_ready),
    .next_ready_i (accum_ready),
    .term_o       (term)
  );

  rfa_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .term_i      (term),
    .in_ready_o  (accum_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .fitness_o   (m_axis_tdata_o),
    .saturated_o (m_axis_tuser_o)
  );

  // A clamped sum is always reported at its maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o == rfa_pkg::FIT_W'(rfa_pkg::SUM_MAX))
    else $error("saturated result is not at maximum");

  // A new result only follows a last item leaving the term stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(term.valid && term.last && accum_ready))
    else $error("result without a last item");

  // Input stalls only when every stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> lookup.valid && term.valid && m_axis_tvalid_o)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire
